// ===== hdl/drcc_pkg.sv =====
package drcc_pkg;

  localparam logic [3:0] FN_ABS    = 4'd0;
  localparam logic [3:0] FN_SIGN   = 4'd1;
  localparam logic [3:0] FN_FINITE = 4'd2;
  localparam logic [3:0] FN_INF    = 4'd3;
  localparam logic [3:0] FN_NAN    = 4'd4;
  localparam logic [3:0] FN_CLAMP  = 4'd5;
  localparam logic [3:0] FN_ROUND  = 4'd6;
  localparam logic [3:0] FN_FLOOR  = 4'd7;
  localparam logic [3:0] FN_CEIL   = 4'd8;
  localparam logic [3:0] FN_TRUNC  = 4'd9;
  localparam logic [3:0] FN_IROUND = 4'd10;
  localparam logic [3:0] FN_IFLOOR = 4'd11;
  localparam logic [3:0] FN_ICEIL  = 4'd12;
  localparam logic [3:0] FN_ITRUNC = 4'd13;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_ORDER = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  localparam logic [1:0] RM_NEAR  = 2'd0;
  localparam logic [1:0] RM_FLOOR = 2'd1;
  localparam logic [1:0] RM_CEIL  = 2'd2;
  localparam logic [1:0] RM_TRUNC = 2'd3;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] INT_BOUND = 64'h7FFF_FFFF_FFFF_FC00;

  typedef struct packed {
    logic [3:0]  func;
    logic [63:0] value_bits;
    logic [63:0] lower_bits;
    logic [63:0] upper_bits;
  } drcc_in_t;

  typedef struct packed {
    logic [63:0]        real_result;
    logic signed [63:0] int_result;
    logic               flag;
    logic [1:0]         error;
  } drcc_out_t;

  function automatic logic is_nan(input logic [63:0] b);
    is_nan = (&b[62:52]) && (|b[51:0]);
  endfunction

  function automatic logic [63:0] order_key(input logic [63:0] b);
    logic [63:0] z;
    z = (b[62:0] == 63'd0) ? 64'd0 : b;
    order_key = z[63] ? ~z : (z | SIGN_BIT);
  endfunction

endpackage

// ===== hdl/double_round_convert_classify_unit.sv =====
// Channel | Dir | Payload    | Handshake
// in      | in  | drcc_in_t  | in_valid / in_ready
// out     | out | drcc_out_t | out_valid / out_ready
// One item per cycle while out_ready is high; each item passes the input
// register, then the result register. The rate is set by the single-pass
// datapath between them, one item held in each.
// Reset (rst_n low, synchronous) empties both registers.
// A stalled output holds its item; the input register advances when the
// result register is free or being taken.
module double_round_convert_classify_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  drcc_pkg::drcc_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output drcc_pkg::drcc_out_t out_data
);
  import drcc_pkg::*;

  drcc_in_t  in_r;
  logic      in_vld_r;
  drcc_out_t out_r;
  logic      out_vld_r;
  drcc_out_t res;

  logic        adv;
  logic [63:0] v, lo, hi, rnd;
  logic [1:0]  mode;
  logic [11:0] e;       // unbiased exponent, signed
  logic [63:0] mask, addv, rsum;
  logic [5:0]  sh;
  logic [52:0] m;
  logic [63:0] mag;
  logic        neg, nz;
  logic        fin;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (adv) out_vld_r <= in_vld_r;
    end
    if (in_ready && in_valid) in_r <= in_data;
    if (adv && in_vld_r) out_r <= res;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // rounding
  always_comb begin
    v    = in_r.value_bits;
    lo   = in_r.lower_bits;
    hi   = in_r.upper_bits;
    mode = in_r.func[1:0] + 2'd2;  // 6..9 and 10..13 both map to 0..3
    neg  = v[63];
    nz   = v[62:0] != 63'd0;
    e    = {1'b0, v[62:52]} - 12'd1023;
    sh   = 6'd52 - e[5:0];
    mask = (64'd1 << sh) - 64'd1;
    addv = 64'd0;
    unique case (mode)
      RM_NEAR:  addv = 64'd1 << (sh - 6'd1);
      RM_FLOOR: addv = neg ? mask + 64'd1 : 64'd0;
      RM_CEIL:  addv = neg ? 64'd0 : mask + 64'd1;
      default:  addv = 64'd0;
    endcase
    rsum = v + addv;
    if (is_nan(v)) begin
      rnd = v | QUIET_BIT;
    end else if (!e[11] && e >= 12'd52) begin
      rnd = v;
    end else if (e[11]) begin
      unique case (mode)
        RM_NEAR:  rnd = (e == 12'hFFF) ? (v & SIGN_BIT) | ONE_BITS : v & SIGN_BIT;
        RM_FLOOR: rnd = (neg && nz) ? (v & SIGN_BIT) | ONE_BITS : v & SIGN_BIT;
        RM_CEIL:  rnd = (!neg && nz) ? ONE_BITS : v & SIGN_BIT;
        default:  rnd = v & SIGN_BIT;
      endcase
    end else if ((v & mask) == 64'd0) begin
      rnd = v;
    end else begin
      rnd = rsum & ~mask;
    end
  end

  // integer conversion of the rounded value
  logic [11:0] re;
  logic        rint_ok;
  logic [63:0] ival;
  always_comb begin
    re  = {1'b0, rnd[62:52]} - 12'd1023;
    m   = {1'b1, rnd[51:0]};
    mag = 64'd0;
    if (!re[11]) begin
      if (re >= 12'd52) mag = {11'd0, m} << (re[5:0] - 6'd52);
      else              mag = {11'd0, m} >> (6'd52 - re[5:0]);
    end
    rint_ok = 1'b1;
    ival    = 64'd0;
    if (is_nan(rnd) || (!re[11] && re > 12'd63)) begin
      rint_ok = 1'b0;
    end else if (!re[11]) begin
      if (rnd[63]) begin
        if (mag > SIGN_BIT) rint_ok = 1'b0;
        else ival = 64'd0 - mag;
      end else begin
        if (mag > INT_BOUND) rint_ok = 1'b0;
        else ival = mag;
      end
    end
  end

  always_comb begin
    fin = !(&v[62:52]);
    res = '0;
    unique case (in_r.func)
      FN_ABS:    res.real_result = v & ~SIGN_BIT;
      FN_SIGN:   res.int_result = v[63] ? -64'sd1 : 64'sd0;
      FN_FINITE: res.flag = fin;
      FN_INF:    res.flag = !fin && (v[51:0] == 52'd0);
      FN_NAN:    res.flag = is_nan(v);
      FN_CLAMP: begin
        if (is_nan(lo) || is_nan(hi) || order_key(lo) > order_key(hi))
          res.error = ERR_ORDER;
        else if (is_nan(v))                      res.real_result = v;
        else if (order_key(v) < order_key(lo))   res.real_result = lo;
        else if (order_key(hi) < order_key(v))   res.real_result = hi;
        else                                     res.real_result = v;
      end
      FN_ROUND, FN_FLOOR, FN_CEIL, FN_TRUNC: res.real_result = rnd;
      FN_IROUND, FN_IFLOOR, FN_ICEIL, FN_ITRUNC: begin
        if (rint_ok) res.int_result = ival;
        else         res.error = ERR_RANGE;
      end
      default: res = '0;
    endcase
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(out_r))
    else $error("result dropped while stalled");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && adv |=> out_vld_r)
    else $error("item lost between stages");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.error != ERR_OK |-> out_r.int_result == 64'sd0)
    else $error("error with nonzero integer");
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import drcc_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  drcc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  drcc_out_t out_data;

  double_round_convert_classify_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  localparam logic [63:0] EXP_ALL  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] MANT_ALL = 64'h000F_FFFF_FFFF_FFFF;
  localparam int          STALL_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT = 5000;

  drcc_out_t pending_results[$];
  int  failures = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 1'b0;
  int  quiet_cycles = 0;

  function automatic logic nan_bits(input logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  function automatic logic [63:0] sort_key(input logic [63:0] b);
    logic [63:0] z;
    z = (b[62:0] == 63'd0) ? 64'd0 : b;
    return z[63] ? ~z : (z | SIGN_BIT);
  endfunction

  function automatic logic [63:0] round_integral(input logic [63:0] b, input logic [1:0] rm);
    int          e;
    logic [63:0] mask;
    logic [63:0] sgn;
    logic        neg;
    logic        nz;
    sgn = b & SIGN_BIT;
    neg = b[63];
    e = int'(b[62:52]) - 1023;
    nz = b[62:0] != 63'd0;
    if (nan_bits(b)) return b | QUIET_BIT;
    if (e >= 52) return b;
    if (e < 0) begin
      case (rm)
        RM_NEAR:  return (e == -1) ? (sgn | ONE_BITS) : sgn;
        RM_FLOOR: return (neg && nz) ? (sgn | ONE_BITS) : sgn;
        RM_CEIL:  return (!neg && nz) ? ONE_BITS : sgn;
        default:  return sgn;
      endcase
    end
    mask = (64'd1 << (52 - e)) - 64'd1;
    if ((b & mask) == 64'd0) return b;
    case (rm)
      RM_NEAR:  b = b + (64'd1 << (51 - e));
      RM_FLOOR: if (neg) b = b + mask + 64'd1;
      RM_CEIL:  if (!neg) b = b + mask + 64'd1;
      default: ;
    endcase
    return b & ~mask;
  endfunction

  // Returns 1 when the integral double fits in int64.
  function automatic logic integral_to_int(input logic [63:0] b, output logic [63:0] res);
    int          e;
    logic [63:0] m;
    logic [63:0] mag;
    e = int'(b[62:52]) - 1023;
    res = 64'd0;
    if (nan_bits(b) || e > 63) return 1'b0;
    if (e < 0) return 1'b1;
    m = (b & MANT_ALL) | (64'd1 << 52);
    mag = (e >= 52) ? (m << (e - 52)) : (m >> (52 - e));
    if (b[63]) begin
      if (mag > SIGN_BIT) return 1'b0;
      res = 64'd0 - mag;
    end else begin
      if (mag > INT_BOUND) return 1'b0;
      res = mag;
    end
    return 1'b1;
  endfunction

  function automatic drcc_out_t predict_result(input drcc_in_t it);
    drcc_out_t   r;
    logic [63:0] v;
    logic [63:0] iv;
    logic        fin;
    r = '0;
    v = it.value_bits;
    fin = (v & EXP_ALL) != EXP_ALL;
    case (it.func)
      FN_ABS:    r.real_result = v & ~SIGN_BIT;
      FN_SIGN:   r.int_result = v[63] ? -64'sd1 : 64'sd0;
      FN_FINITE: r.flag = fin;
      FN_INF:    r.flag = !fin && (v[51:0] == 52'd0);
      FN_NAN:    r.flag = nan_bits(v);
      FN_CLAMP: begin
        if (nan_bits(it.lower_bits) || nan_bits(it.upper_bits) ||
            sort_key(it.lower_bits) > sort_key(it.upper_bits)) r.error = ERR_ORDER;
        else if (nan_bits(v)) r.real_result = v;
        else if (sort_key(v) < sort_key(it.lower_bits)) r.real_result = it.lower_bits;
        else if (sort_key(it.upper_bits) < sort_key(v)) r.real_result = it.upper_bits;
        else r.real_result = v;
      end
      FN_ROUND, FN_FLOOR, FN_CEIL, FN_TRUNC:
        r.real_result = round_integral(v, 2'(it.func - FN_ROUND));
      FN_IROUND, FN_IFLOOR, FN_ICEIL, FN_ITRUNC: begin
        if (!integral_to_int(round_integral(v, 2'(it.func - FN_IROUND)), iv))
          r.error = ERR_RANGE;
        r.int_result = iv;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Hold valid between items; drop it only for idle cycles.
  task automatic send_item(input drcc_in_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    pending_results.push_back(predict_result(it));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_op(input logic [3:0] f, input logic [63:0] v,
                         input logic [63:0] lo = 64'd0, input logic [63:0] hi = 64'd0);
    drcc_in_t it;
    it.func = f;
    it.value_bits = v;
    it.lower_bits = lo;
    it.upper_bits = hi;
    send_item(it);
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] b;
    int          e;
    b = {$urandom, $urandom};
    case ($urandom_range(9))
      0: b[62:52] = 11'h7FF;
      1: b[62:52] = 11'h000;
      2, 3: b[62:52] = 11'(1023 + $urandom_range(52, 66));
      default: begin
        e = $urandom_range(0, 62);
        b[62:52] = 11'(1023 - 2 + e);
      end
    endcase
    if ($urandom_range(7) == 0) b[51:0] = b[51:0] & ~((52'd1 << $urandom_range(51)) - 52'd1);
    return b;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(FN_ABS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(FN_SIGN, 64'h8000_0000_0000_0000);
    send_op(FN_SIGN, 64'h0000_0000_0000_0000);
    send_op(FN_FINITE, 64'h7FF0_0000_0000_0000);
    send_op(FN_INF, 64'hFFF0_0000_0000_0000);
    send_op(FN_NAN, 64'h7FF0_0000_0000_0001);
    // clamp: swapped limits, NaN limit, NaN operand, equal zeros
    send_op(FN_CLAMP, 64'h4000_0000_0000_0000, 64'h4008_0000_0000_0000, ONE_BITS);
    send_op(FN_CLAMP, ONE_BITS, 64'h7FF8_0000_0000_0000, ONE_BITS);
    send_op(FN_CLAMP, 64'hFFF4_0000_0000_0001, 64'd0, ONE_BITS);
    send_op(FN_CLAMP, 64'h8000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0000);
    send_op(FN_CLAMP, 64'h4010_0000_0000_0000, 64'd0, ONE_BITS);
    send_op(FN_CLAMP, 64'hC010_0000_0000_0000, 64'd0, ONE_BITS);
    send_op(FN_ROUND, 64'hBFE0_0000_0000_0000);  // -0.5
    send_op(FN_FLOOR, 64'hBFD0_0000_0000_0000);
    send_op(FN_CEIL, 64'hBFD0_0000_0000_0000);
    send_op(FN_TRUNC, 64'h7FF4_0000_0000_0000);
    send_op(FN_ROUND, 64'h4004_0000_0000_0000);  // 2.5
    send_op(FN_IROUND, 64'hC3E0_0000_0000_0000); // -2^63
    send_op(FN_IFLOOR, 64'hC3E0_0000_0000_0001);
    send_op(FN_ICEIL, 64'h43DF_FFFF_FFFF_FFFF);
    send_op(FN_ITRUNC, 64'h43E0_0000_0000_0000);
    send_op(FN_ITRUNC, 64'h7FF8_0000_0000_0000);
    send_op(4'd14, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(4'd15, 64'd0);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    drcc_in_t it;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      it.func = ($urandom_range(19) == 0) ? 4'($urandom_range(14, 15))
                                          : 4'($urandom_range(0, 13));
      it.value_bits = rand_double();
      it.lower_bits = rand_double();
      it.upper_bits = rand_double();
      if (it.func == FN_CLAMP && $urandom_range(3) != 0 &&
          sort_key(it.lower_bits) > sort_key(it.upper_bits)) begin
        it.value_bits = it.lower_bits;
        it.lower_bits = it.upper_bits;
        it.upper_bits = it.value_bits;
        if ($urandom_range(1)) it.value_bits = rand_double();
      end
      send_item(it);
    end
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        recv_hold = 1'b0;
      end
      test_random(40, 0, 0);
    join
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !recv_hold &&
                      !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    drcc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.real_result !== want.real_result) begin
          $error("real_result exp %h got %h", want.real_result, out_data.real_result);
          failures++;
        end
        if (out_data.int_result !== want.int_result) begin
          $error("int_result exp %0d got %0d", want.int_result, out_data.int_result);
          failures++;
        end
        if (out_data.flag !== want.flag) begin
          $error("flag exp %b got %b", want.flag, out_data.flag);
          failures++;
        end
        if (out_data.error !== want.error) begin
          $error("error exp %0d got %0d", want.error, out_data.error);
          failures++;
        end
      end
    end
  end

  // Count cycles without any handshake; bail out if the block hangs.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[double_round_convert_classify_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 52, 0);
    test_random(300, 0, 52);
    test_random(300, 17, 17);
    test_backpressure();
    wait_drained();
    repeat (10) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0)
      $display("[double_round_convert_classify_unit] OK");
    else
      $display("[double_round_convert_classify_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/drcc_pkg.sv
hdl/double_round_convert_classify_unit.sv
sim/testbench.sv
